@@ hdl/sfr_pkg.sv @@
// Shared constants and types for the stream find-and-replace block.
// Holds register indexes and the fixed field widths; no dependencies.
package sfr_pkg;

   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 4;
   localparam int CFG_W   = 64;
   localparam int CSR_IDX_W = 3;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [LEN_W-1:0]  len_type;

   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_BYTES  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_LEN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_BYTES   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_LEN     = 3'd4;

   localparam logic MODE_SET     = 1'b0;
   localparam logic MODE_PATTERN = 1'b1;

endpackage

@@ hdl/stream_find_and_replace.sv @@
// Stream find-and-replace: byte stream in, replaced byte stream out.
// Depends on sfr_pkg for register indexes and field widths.
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall | req_in_byte, req_in_last
//   rsp_    | out       | rsp_valid/rsp_stall | rsp_out_byte, rsp_run_last, rsp_stream_end
//   csr_    | in        | csr_valid/csr_ready | csr_index, csr_data
//
// Each word is matched in the cycle it is accepted; its results (up to the larger of
// MATCH_MAX and WORD_MAX bytes) are registered and leave one byte per cycle while rsp_stall is low.
// A word giving one byte is accepted every cycle while rsp_stall is low; a word giving n bytes
// holds the output register until all n have left, and a one-deep skid stage lets one further word in.
// Synchronous active-high reset clears the configuration registers (match length is set to 1),
// the held count, the output pointer and the stage valid flags; held and buffered bytes are left as they are.
// req_stall is high exactly while the skid stage is occupied.
module stream_find_and_replace
   import sfr_pkg::*;
#(
   parameter int MATCH_MAX = 8,
   parameter int WORD_MAX  = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_in_byte,
   input  logic                 req_in_last,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BYTE_W-1:0]    rsp_out_byte,
   output logic                 rsp_run_last,
   output logic                 rsp_stream_end,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   localparam int RES_MAX = (MATCH_MAX > WORD_MAX) ? MATCH_MAX : WORD_MAX;
   localparam int NUM_W   = $clog2(RES_MAX + 1);
   localparam int PTR_W   = (RES_MAX > 1) ? $clog2(RES_MAX) : 1;
   localparam int CNT_W   = $clog2(MATCH_MAX + 1);
   localparam len_type MATCH_MAX_L = len_type'(MATCH_MAX);
   localparam len_type WORD_MAX_L  = len_type'(WORD_MAX);

   // Configuration registers.
   logic              mode_ff;
   logic [CFG_W-1:0]  match_bytes_ff;
   len_type           match_len_ff;
   logic [CFG_W-1:0]  word_bytes_ff;
   len_type           word_len_ff;

   // Held window of a possible partial match.
   byte_type          held_ff [MATCH_MAX];
   byte_type          held_in [MATCH_MAX];
   logic [CNT_W-1:0]  held_count_ff;
   logic [CNT_W-1:0]  held_count_in;

   // Results of the word being accepted.
   byte_type          new_bytes [RES_MAX];
   logic [NUM_W-1:0]  new_num;

   // Skid stage and output stage.
   logic              a_valid_ff, a_valid_in;
   byte_type          a_bytes_ff [RES_MAX];
   logic [NUM_W-1:0]  a_num_ff;
   logic              a_last_ff;
   logic              b_valid_ff, b_valid_in;
   byte_type          b_bytes_ff [RES_MAX];
   logic [NUM_W-1:0]  b_num_ff;
   logic              b_last_ff;
   logic [PTR_W-1:0]  b_ptr_ff, b_ptr_in;

   logic              accept;
   logic              wr_cfg;
   logic              b_end;
   logic              b_done;
   logic              b_free;
   logic              load_b_from_a;
   logic              load_b_new;
   logic              load_a_new;

   assign csr_ready = 1'b1;
   assign wr_cfg    = csr_valid && csr_ready;
   assign req_stall = a_valid_ff;
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------- matching
   always_comb begin
      len_type  len;
      len_type  wl;
      len_type  cnt0;
      len_type  cnt1;
      byte_type win [MATCH_MAX];
      logic     hit;
      logic     same;
      logic     full;
      logic     sel_word;
      logic     sel_win;
      byte_type wb;
      byte_type wn;

      len  = (match_len_ff > MATCH_MAX_L) ? MATCH_MAX_L : match_len_ff;
      wl   = (word_len_ff > WORD_MAX_L) ? WORD_MAX_L : word_len_ff;
      cnt0 = len_type'(held_count_ff);
      if (len == '0 || cnt0 > len - len_type'(1)) begin
         cnt0 = '0;
      end
      cnt1 = cnt0 + len_type'(1);
      full = (cnt1 == len);

      for (int i = 0; i < MATCH_MAX; i++) begin
         win[i] = (len_type'(i) == cnt0) ? req_in_byte : held_ff[i];
      end

      hit  = 1'b0;
      same = 1'b1;
      for (int i = 0; i < 8; i++) begin
         if (len_type'(i) < len && match_bytes_ff[8*i +: 8] == req_in_byte) begin
            hit = 1'b1;
         end
      end
      for (int i = 0; i < MATCH_MAX; i++) begin
         if (len_type'(i) < len && win[i] != match_bytes_ff[8*i +: 8]) begin
            same = 1'b0;
         end
      end

      sel_word      = 1'b0;
      sel_win       = 1'b0;
      new_num       = NUM_W'(1);
      held_count_in = '0;
      for (int i = 0; i < MATCH_MAX; i++) begin
         held_in[i] = win[i];
      end

      if (mode_ff == MODE_SET) begin
         if (hit) begin
            sel_word = 1'b1;
            new_num  = NUM_W'(wl);
         end
      end else if (len != '0) begin
         sel_win = 1'b1;
         if (full && same) begin
            sel_word = 1'b1;
            new_num  = NUM_W'(wl);
         end else if (full) begin
            // The oldest byte leaves; the rest slide down one place.
            for (int i = 0; i < MATCH_MAX; i++) begin
               held_in[i] = win[(i + 1) % MATCH_MAX];
            end
            new_num       = req_in_last ? NUM_W'(len) : NUM_W'(1);
            held_count_in = req_in_last ? '0 : CNT_W'(len - len_type'(1));
         end else begin
            new_num       = req_in_last ? NUM_W'(cnt1) : '0;
            held_count_in = req_in_last ? '0 : CNT_W'(cnt1);
         end
      end

      for (int i = 0; i < RES_MAX; i++) begin
         wb = (i < WORD_MAX) ? word_bytes_ff[8*i +: 8] : '0;
         wn = (i < MATCH_MAX) ? win[i % MATCH_MAX] : '0;
         if (sel_word) begin
            new_bytes[i] = wb;
         end else if (sel_win) begin
            new_bytes[i] = wn;
         end else begin
            new_bytes[i] = req_in_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_SET;
         match_bytes_ff <= '0;
         match_len_ff   <= len_type'(1);
         word_bytes_ff  <= '0;
         word_len_ff    <= '0;
         held_count_ff  <= '0;
      end else if (wr_cfg) begin
         case (csr_index)
            CSR_REPLACE_MODE: begin
               mode_ff       <= csr_data[0];
               held_count_ff <= '0;
            end
            CSR_MATCH_BYTES: match_bytes_ff <= csr_data;
            CSR_MATCH_LEN: begin
               match_len_ff  <= csr_data[LEN_W-1:0];
               held_count_ff <= '0;
            end
            CSR_WORD_BYTES: word_bytes_ff <= csr_data;
            CSR_WORD_LEN:   word_len_ff   <= csr_data[LEN_W-1:0];
            default: ;
         endcase
      end else if (accept) begin
         held_count_ff <= held_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   // ---------------------------------------------------------------- buffering
   assign b_end  = (NUM_W'(b_ptr_ff) == b_num_ff - NUM_W'(1));
   assign b_done = b_valid_ff && !rsp_stall && b_end;
   assign b_free = !b_valid_ff || b_done;

   always_comb begin
      load_b_from_a = b_free && a_valid_ff;
      load_b_new    = b_free && !a_valid_ff && accept && new_num != '0;
      load_a_new    = !b_free && accept && new_num != '0;

      a_valid_in = a_valid_ff;
      if (load_b_from_a) begin
         a_valid_in = 1'b0;
      end else if (load_a_new) begin
         a_valid_in = 1'b1;
      end

      b_valid_in = b_valid_ff;
      b_ptr_in   = b_ptr_ff;
      if (load_b_from_a || load_b_new) begin
         b_valid_in = 1'b1;
         b_ptr_in   = '0;
      end else if (b_done) begin
         b_valid_in = 1'b0;
      end else if (b_valid_ff && !rsp_stall) begin
         b_ptr_in = b_ptr_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         b_ptr_ff   <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         b_ptr_ff   <= b_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_a_new) begin
         a_bytes_ff <= new_bytes;
         a_num_ff   <= new_num;
         a_last_ff  <= req_in_last;
      end
      if (load_b_from_a) begin
         b_bytes_ff <= a_bytes_ff;
         b_num_ff   <= a_num_ff;
         b_last_ff  <= a_last_ff;
      end else if (load_b_new) begin
         b_bytes_ff <= new_bytes;
         b_num_ff   <= new_num;
         b_last_ff  <= req_in_last;
      end
   end

   assign rsp_valid      = b_valid_ff;
   assign rsp_out_byte   = b_bytes_ff[b_ptr_ff];
   assign rsp_run_last   = b_end;
   assign rsp_stream_end = b_end && b_last_ff;

endmodule
